[rtl/pavr_pkg.sv]
// ----------------------------------------------------------------------------
// pavr_pkg
// Shared types, constants and the arctangent table of the principal-axis
// vector rotator.
// ----------------------------------------------------------------------------
package pavr_pkg;

   localparam int COORD_WIDTH_DEFAULT     = 32;
   localparam int TRIG_ITERATIONS_DEFAULT = 16;

   localparam int ANGLE_WIDTH  = 18;   // angle field, 1/256 degree
   localparam int TURN_WIDTH   = 17;   // reduced angle, 0 .. FULL_TURN-1
   localparam int FRAC_WIDTH   = 15;   // angle within a quadrant
   localparam int TRIG_WIDTH   = 32;   // sin / cos, Q2.30
   localparam int TRIG_FRAC    = 30;
   localparam int PHASE_WIDTH  = 32;   // CORDIC residual angle, Q2.30 radians
   localparam int CORDIC_WIDTH = 33;   // CORDIC x / y datapath
   localparam int ATAN_COUNT   = 24;

   // angle units
   localparam int FULL_TURN          = 92160;
   localparam int QUARTER_TURN       = 23040;
   localparam int HALF_TURN          = 46080;
   localparam int THREE_QUARTER_TURN = 69120;

   // radians = f * pi / HALF_TURN, split as f * PI_WHOLE + f * PI_FRAC / HALF_TURN
   localparam int PI_WHOLE       = 73204;
   localparam int PI_FRAC        = 19106;
   localparam int PHASE_BIAS     = 23040;  // round-to-nearest bias
   localparam int NUM_WIDTH      = 29;
   // floor(n / HALF_TURN) == (n * RECIP_HALF) >> RECIP_SHIFT for n < 2^29
   localparam int RECIP_WIDTH    = 30;
   localparam int RECIP_HALF     = 763549742;
   localparam int RECIP_SHIFT    = 45;

   localparam int CORDIC_GAIN    = 652032874;   // 1/K in Q2.30
   localparam int ONE_Q30        = 1073741824;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   // atan(2^-i) in Q2.30, truncated
   function automatic logic signed [PHASE_WIDTH-1:0] atan_q30(input logic [4:0] idx);
      logic signed [PHASE_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = 32'sh3243F6A8;
         5'd1:    val = 32'sh1DAC6705;
         5'd2:    val = 32'sh0FADBAFC;
         5'd3:    val = 32'sh07F56EA6;
         5'd4:    val = 32'sh03FEAB76;
         5'd5:    val = 32'sh01FFD55B;
         5'd6:    val = 32'sh00FFFAAA;
         5'd7:    val = 32'sh007FFF55;
         5'd8:    val = 32'sh003FFFEA;
         5'd9:    val = 32'sh001FFFFD;
         5'd10:   val = 32'sh000FFFFF;
         5'd11:   val = 32'sh0007FFFF;
         5'd12:   val = 32'sh0003FFFF;
         5'd13:   val = 32'sh0001FFFF;
         5'd14:   val = 32'sh0000FFFF;
         5'd15:   val = 32'sh00007FFF;
         5'd16:   val = 32'sh00003FFF;
         5'd17:   val = 32'sh00001FFF;
         5'd18:   val = 32'sh00000FFF;
         5'd19:   val = 32'sh000007FF;
         5'd20:   val = 32'sh000003FF;
         5'd21:   val = 32'sh000001FF;
         5'd22:   val = 32'sh000000FF;
         5'd23:   val = 32'sh0000007F;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[rtl/pavr_req_if.sv]
// ----------------------------------------------------------------------------
// pavr_req_if
// Request channel of the rotator: axis code, angle and point.
// ----------------------------------------------------------------------------
interface pavr_req_if #(
   parameter int COORD_WIDTH = pavr_pkg::COORD_WIDTH_DEFAULT
);
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              axis_select;
   logic signed [pavr_pkg::ANGLE_WIDTH-1:0] angle;
   logic signed [COORD_WIDTH-1:0]           point_x;
   logic signed [COORD_WIDTH-1:0]           point_y;
   logic signed [COORD_WIDTH-1:0]           point_z;

   modport source (
      output valid, axis_select, angle, point_x, point_y, point_z,
      input  ready
   );

   modport sink (
      input  valid, axis_select, angle, point_x, point_y, point_z,
      output ready
   );
endinterface

[rtl/pavr_rsp_if.sv]
// ----------------------------------------------------------------------------
// pavr_rsp_if
// Response channel of the rotator: the rotated point.
// ----------------------------------------------------------------------------
interface pavr_rsp_if #(
   parameter int COORD_WIDTH = pavr_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rotated_x;
   logic signed [COORD_WIDTH-1:0] rotated_y;
   logic signed [COORD_WIDTH-1:0] rotated_z;

   modport source (
      output valid, rotated_x, rotated_y, rotated_z,
      input  ready
   );

   modport sink (
      input  valid, rotated_x, rotated_y, rotated_z,
      output ready
   );
endinterface

[rtl/principal_axis_vector_rotator.sv]
// ----------------------------------------------------------------------------
// principal_axis_vector_rotator
// Rotates a Q.16 point about the X, Y or Z axis by a signed angle, using an
// unrolled CORDIC for sine and cosine and a pipelined multiply stage.
// ----------------------------------------------------------------------------
// Usage: one transaction on req_chan gives exactly one transaction on
// rsp_chan, in order. The block takes a new point every clock while the
// skid register is empty. The pipeline is the unrolled CORDIC, one
// register stage per iteration, plus angle reduction (5 stages), the
// sine/cosine fold (1 stage) and the split 32x32 products with rounding and
// saturation (4 stages). When rsp_chan stalls, the waiting result moves into
// a skid register and the pipeline holds for as long as that register is
// occupied; req_chan.ready is a register output and never depends on
// rsp_chan.ready. Angles are in 1/256 degree and wrap modulo 360 degrees.
// Sine and cosine are Q2.30; every product is rounded to nearest with halves
// away from zero, and each rotated coordinate saturates to the coordinate
// range. The axis coordinate, and the whole point for the pass-through code,
// come back bit for bit.
// ----------------------------------------------------------------------------
module principal_axis_vector_rotator #(
   parameter int COORD_WIDTH     = pavr_pkg::COORD_WIDTH_DEFAULT,
   parameter int TRIG_ITERATIONS = pavr_pkg::TRIG_ITERATIONS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   pavr_req_if.sink   req_chan,
   pavr_rsp_if.source rsp_chan
);

   localparam int CW   = COORD_WIDTH;
   localparam int N    = TRIG_ITERATIONS;
   localparam int TW   = pavr_pkg::TRIG_WIDTH;
   localparam int XW   = pavr_pkg::CORDIC_WIDTH;
   localparam int ZW   = pavr_pkg::PHASE_WIDTH;
   localparam int RTW  = pavr_pkg::TURN_WIDTH;
   localparam int FW   = pavr_pkg::FRAC_WIDTH;
   localparam int NW   = pavr_pkg::NUM_WIDTH;
   localparam int AEW  = pavr_pkg::ANGLE_WIDTH + 2;          // room for +2 turns
   localparam int PRW  = pavr_pkg::NUM_WIDTH + pavr_pkg::RECIP_WIDTH;
   localparam int QUW  = PRW - pavr_pkg::RECIP_SHIFT;        // quotient bits
   localparam int LOW  = 16;                                 // low split of a coord
   localparam int HIW  = CW + 1 - LOW;                       // signed high split
   localparam int PHW  = HIW + TW;
   localparam int PLW  = LOW + 1 + TW;
   localparam int PW   = CW + 34;                            // exact product
   localparam int RW   = PW - pavr_pkg::TRIG_FRAC;           // rounded term
   localparam int SW   = RW + 1;                             // row sum

   localparam logic signed [AEW-1:0] TURN_S  = AEW'(pavr_pkg::FULL_TURN);
   localparam logic signed [AEW-1:0] TURN2_S = AEW'(2 * pavr_pkg::FULL_TURN);
   localparam logic [RTW-1:0] QTR_T   = RTW'(pavr_pkg::QUARTER_TURN);
   localparam logic [RTW-1:0] HALF_T  = RTW'(pavr_pkg::HALF_TURN);
   localparam logic [RTW-1:0] TQTR_T  = RTW'(pavr_pkg::THREE_QUARTER_TURN);
   localparam logic [ZW-1:0]  PI_WHOLE_Z = ZW'(pavr_pkg::PI_WHOLE);
   localparam logic [NW-1:0]  PI_FRAC_N  = NW'(pavr_pkg::PI_FRAC);
   localparam logic [NW-1:0]  BIAS_N     = NW'(pavr_pkg::PHASE_BIAS);
   localparam logic [PRW-1:0] RECIP_P    = PRW'(pavr_pkg::RECIP_HALF);
   localparam logic signed [XW-1:0] GAIN_X = XW'(pavr_pkg::CORDIC_GAIN);
   localparam logic signed [XW-1:0] ONE_X  = XW'(pavr_pkg::ONE_Q30);
   localparam logic signed [TW-1:0] ONE_T  = TW'(pavr_pkg::ONE_Q30);
   localparam logic signed [PW-1:0] HALF_P = PW'(pavr_pkg::ONE_Q30 / 2);
   localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(CW-1){1'b1}}});
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // u, v are the coordinates in the rotation plane, w the one on the axis
   typedef struct packed {
      pavr_pkg::axis_type     axis;
      logic signed [CW-1:0]   u;
      logic signed [CW-1:0]   v;
      logic signed [CW-1:0]   w;
   } side_type;

   logic adv;   // whole pipeline moves when the skid register is empty

   // ------------------------------------------------------------------
   // Stage 1: wrap angle into [0, full turn), pick the rotation plane
   // ------------------------------------------------------------------
   logic signed [AEW-1:0] ang_ext;
   logic signed [AEW-1:0] wrap_sum;
   logic [RTW-1:0]        s1_turn_in;
   side_type              s1_side_in;
   logic                  s1_valid_ff;
   logic [RTW-1:0]        s1_turn_ff;
   side_type              s1_side_ff;

   always_comb begin
      ang_ext = AEW'(req_chan.angle);
      if (ang_ext < -TURN_S) begin
         wrap_sum = ang_ext + TURN2_S;
      end else if (ang_ext < 0) begin
         wrap_sum = ang_ext + TURN_S;
      end else if (ang_ext >= TURN_S) begin
         wrap_sum = ang_ext - TURN_S;
      end else begin
         wrap_sum = ang_ext;
      end
      s1_turn_in = wrap_sum[RTW-1:0];

      s1_side_in.axis = pavr_pkg::axis_type'(req_chan.axis_select);
      case (s1_side_in.axis)
         pavr_pkg::AXIS_X: begin
            s1_side_in.u = req_chan.point_y;
            s1_side_in.v = req_chan.point_z;
            s1_side_in.w = req_chan.point_x;
         end
         pavr_pkg::AXIS_Y: begin
            s1_side_in.u = req_chan.point_z;
            s1_side_in.v = req_chan.point_x;
            s1_side_in.w = req_chan.point_y;
         end
         default: begin
            // about Z, and pass-through keeps x, y, z in u, v, w
            s1_side_in.u = req_chan.point_x;
            s1_side_in.v = req_chan.point_y;
            s1_side_in.w = req_chan.point_z;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (adv) begin
         s1_turn_ff <= s1_turn_in;
         s1_side_ff <= s1_side_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: quadrant and angle within the quadrant
   // ------------------------------------------------------------------
   quad_type        s2_quad_in;
   logic [RTW-1:0]  quad_base;
   logic [RTW-1:0]  frac_diff;
   logic            s2_valid_ff;
   quad_type        s2_quad_ff;
   logic [FW-1:0]   s2_frac_ff;
   side_type        s2_side_ff;

   always_comb begin
      if (s1_turn_ff >= TQTR_T) begin
         s2_quad_in = QUAD_3;
         quad_base  = TQTR_T;
      end else if (s1_turn_ff >= HALF_T) begin
         s2_quad_in = QUAD_2;
         quad_base  = HALF_T;
      end else if (s1_turn_ff >= QTR_T) begin
         s2_quad_in = QUAD_1;
         quad_base  = QTR_T;
      end else begin
         s2_quad_in = QUAD_0;
         quad_base  = '0;
      end
      frac_diff = s1_turn_ff - quad_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_quad_ff <= s2_quad_in;
         s2_frac_ff <= frac_diff[FW-1:0];
         s2_side_ff <= s1_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: radians = f*PI_WHOLE + (f*PI_FRAC + bias) / half turn
   // ------------------------------------------------------------------
   logic            s3_valid_ff;
   quad_type        s3_quad_ff;
   logic            s3_zero_ff;
   logic [ZW-1:0]   s3_whole_ff;
   logic [NW-1:0]   s3_num_ff;
   side_type        s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s3_quad_ff  <= s2_quad_ff;
         s3_zero_ff  <= (s2_frac_ff == '0);
         s3_whole_ff <= ZW'(s2_frac_ff) * PI_WHOLE_Z;
         s3_num_ff   <= NW'(s2_frac_ff) * PI_FRAC_N + BIAS_N;
         s3_side_ff  <= s2_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: divide by the half turn through a reciprocal product
   // ------------------------------------------------------------------
   logic [PRW-1:0]  recip_prod;
   logic            s4_valid_ff;
   quad_type        s4_quad_ff;
   logic            s4_zero_ff;
   logic [ZW-1:0]   s4_whole_ff;
   logic [QUW-1:0]  s4_quo_ff;
   side_type        s4_side_ff;

   assign recip_prod = PRW'(s3_num_ff) * RECIP_P;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv) begin
         s4_quad_ff  <= s3_quad_ff;
         s4_zero_ff  <= s3_zero_ff;
         s4_whole_ff <= s3_whole_ff;
         s4_quo_ff   <= recip_prod[PRW-1:pavr_pkg::RECIP_SHIFT];
         s4_side_ff  <= s3_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: starting phase of the CORDIC
   // ------------------------------------------------------------------
   logic            s5_valid_ff;
   quad_type        s5_quad_ff;
   logic            s5_zero_ff;
   logic [ZW-1:0]   s5_phase_ff;
   side_type        s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (adv) begin
         s5_quad_ff  <= s4_quad_ff;
         s5_zero_ff  <= s4_zero_ff;
         s5_phase_ff <= s4_whole_ff + ZW'(s4_quo_ff);
         s5_side_ff  <= s4_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // CORDIC, rotation mode, one register stage per iteration.
   // Index k is the input of iteration k; index N is the result.
   // ------------------------------------------------------------------
   logic                  cv    [0:N];
   quad_type              cq    [0:N];
   logic                  czero [0:N];
   logic signed [XW-1:0]  cx    [0:N];
   logic signed [XW-1:0]  cy    [0:N];
   logic signed [ZW-1:0]  cz    [0:N];
   side_type              cside [0:N];

   assign cv[0]    = s5_valid_ff;
   assign cq[0]    = s5_quad_ff;
   assign czero[0] = s5_zero_ff;
   assign cx[0]    = GAIN_X;
   assign cy[0]    = '0;
   assign cz[0]    = $signed(s5_phase_ff);
   assign cside[0] = s5_side_ff;

   for (genvar k = 0; k < N; k++) begin : g_cordic
      localparam logic signed [ZW-1:0] ATAN_K = pavr_pkg::atan_q30(5'(k));

      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [ZW-1:0] z_in;
      logic                 valid_ff;
      quad_type             quad_ff;
      logic                 zero_ff;
      logic signed [XW-1:0] x_ff;
      logic signed [XW-1:0] y_ff;
      logic signed [ZW-1:0] z_ff;
      side_type             side_ff;

      always_comb begin
         dx = cy[k] >>> k;
         dy = cx[k] >>> k;
         if (!cz[k][ZW-1]) begin
            x_in = cx[k] - dx;
            y_in = cy[k] + dy;
            z_in = cz[k] - ATAN_K;
         end else begin
            x_in = cx[k] + dx;
            y_in = cy[k] - dy;
            z_in = cz[k] + ATAN_K;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= cv[k];
         end
         if (adv) begin
            quad_ff <= cq[k];
            zero_ff <= czero[k];
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
            side_ff <= cside[k];
         end
      end

      assign cv[k+1]    = valid_ff;
      assign cq[k+1]    = quad_ff;
      assign czero[k+1] = zero_ff;
      assign cx[k+1]    = x_ff;
      assign cy[k+1]    = y_ff;
      assign cz[k+1]    = z_ff;
      assign cside[k+1] = side_ff;
   end

   // ------------------------------------------------------------------
   // Clamp to +/-1.0, exact values on quadrant edges, fold by quadrant
   // ------------------------------------------------------------------
   logic signed [TW-1:0] cos0;
   logic signed [TW-1:0] sin0;
   logic signed [TW-1:0] cos_in;
   logic signed [TW-1:0] sin_in;
   logic                 sq_valid_ff;
   logic signed [TW-1:0] sq_cos_ff;
   logic signed [TW-1:0] sq_sin_ff;
   side_type             sq_side_ff;

   always_comb begin
      if (czero[N]) begin
         cos0 = ONE_T;
         sin0 = '0;
      end else begin
         if (cx[N] > ONE_X) begin
            cos0 = ONE_T;
         end else if (cx[N] < -ONE_X) begin
            cos0 = -ONE_T;
         end else begin
            cos0 = cx[N][TW-1:0];
         end
         if (cy[N] > ONE_X) begin
            sin0 = ONE_T;
         end else if (cy[N] < -ONE_X) begin
            sin0 = -ONE_T;
         end else begin
            sin0 = cy[N][TW-1:0];
         end
      end

      case (cq[N])
         QUAD_0: begin
            cos_in = cos0;
            sin_in = sin0;
         end
         QUAD_1: begin
            cos_in = -sin0;
            sin_in = cos0;
         end
         QUAD_2: begin
            cos_in = -cos0;
            sin_in = -sin0;
         end
         default: begin
            cos_in = sin0;
            sin_in = -cos0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (adv) begin
         sq_valid_ff <= cv[N];
      end
      if (adv) begin
         sq_cos_ff  <= cos_in;
         sq_sin_ff  <= sin_in;
         sq_side_ff <= cside[N];
      end
   end

   // ------------------------------------------------------------------
   // Products u*c, v*s, u*s, v*c: split multiply, sum, round
   // ------------------------------------------------------------------
   logic     p1_valid_ff;
   side_type p1_side_ff;
   logic     p2_valid_ff;
   side_type p2_side_ff;
   logic     p3_valid_ff;
   side_type p3_side_ff;

   logic signed [RW-1:0] term [0:3];

   for (genvar g = 0; g < 4; g++) begin : g_prod
      logic signed [CW-1:0]  op_a;
      logic signed [TW-1:0]  op_b;
      logic signed [CW:0]    a_ext;
      logic signed [HIW-1:0] a_hi;
      logic [LOW-1:0]        a_lo;
      logic signed [PW-1:0]  rnd_sum;
      logic signed [PHW-1:0] pph_ff;
      logic signed [PLW-1:0] ppl_ff;
      logic signed [PW-1:0]  prod_ff;
      logic signed [RW-1:0]  term_ff;

      assign op_a  = (g == 0 || g == 2) ? sq_side_ff.u : sq_side_ff.v;
      assign op_b  = (g == 0 || g == 3) ? sq_cos_ff : sq_sin_ff;
      assign a_ext = {op_a[CW-1], op_a};
      assign a_hi  = a_ext[CW:LOW];
      assign a_lo  = a_ext[LOW-1:0];

      // halves away from zero: bias one less for negative products
      assign rnd_sum = prod_ff + (prod_ff[PW-1] ? HALF_P - PW'(1) : HALF_P);

      always_ff @(posedge clock) begin
         if (adv) begin
            pph_ff  <= PHW'(a_hi) * PHW'(op_b);
            ppl_ff  <= PLW'($signed({1'b0, a_lo})) * PLW'(op_b);
            prod_ff <= (PW'(pph_ff) <<< LOW) + PW'(ppl_ff);
            term_ff <= rnd_sum[PW-1:pavr_pkg::TRIG_FRAC];
         end
      end

      assign term[g] = term_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= sq_valid_ff;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
      if (adv) begin
         p1_side_ff <= sq_side_ff;
         p2_side_ff <= p1_side_ff;
         p3_side_ff <= p2_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // Row sums, saturation, map back to x, y, z
   // ------------------------------------------------------------------
   function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] val);
      logic signed [CW-1:0] res;
      if (val > SAT_HI) begin
         res = SAT_HI[CW-1:0];
      end else if (val < SAT_LO) begin
         res = SAT_LO[CW-1:0];
      end else begin
         res = val[CW-1:0];
      end
      return res;
   endfunction

   logic signed [SW-1:0] row_u;
   logic signed [SW-1:0] row_v;
   logic signed [CW-1:0] rot_u;
   logic signed [CW-1:0] rot_v;
   logic signed [CW-1:0] x_in;
   logic signed [CW-1:0] y_in;
   logic signed [CW-1:0] z_in;
   logic                 out_valid_ff;
   logic signed [CW-1:0] out_x_ff;
   logic signed [CW-1:0] out_y_ff;
   logic signed [CW-1:0] out_z_ff;

   always_comb begin
      row_u = SW'(term[0]) - SW'(term[1]);
      row_v = SW'(term[2]) + SW'(term[3]);
      rot_u = sat_coord(row_u);
      rot_v = sat_coord(row_v);
      case (p3_side_ff.axis)
         pavr_pkg::AXIS_X: begin
            x_in = p3_side_ff.w;
            y_in = rot_u;
            z_in = rot_v;
         end
         pavr_pkg::AXIS_Y: begin
            x_in = rot_v;
            y_in = p3_side_ff.w;
            z_in = rot_u;
         end
         pavr_pkg::AXIS_Z: begin
            x_in = rot_u;
            y_in = rot_v;
            z_in = p3_side_ff.w;
         end
         default: begin
            x_in = p3_side_ff.u;
            y_in = p3_side_ff.v;
            z_in = p3_side_ff.w;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= p3_valid_ff;
      end
      if (adv) begin
         out_x_ff <= x_in;
         out_y_ff <= y_in;
         out_z_ff <= z_in;
      end
   end

   // ------------------------------------------------------------------
   // Skid register: catches the last stage when rsp_chan stalls
   // ------------------------------------------------------------------
   logic                 skid_valid_ff;
   logic signed [CW-1:0] skid_x_ff;
   logic signed [CW-1:0] skid_y_ff;
   logic signed [CW-1:0] skid_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_chan.ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (out_valid_ff && !rsp_chan.ready) begin
         skid_valid_ff <= 1'b1;
      end
      if (!skid_valid_ff) begin
         skid_x_ff <= out_x_ff;
         skid_y_ff <= out_y_ff;
         skid_z_ff <= out_z_ff;
      end
   end

   assign adv = !skid_valid_ff;

   assign req_chan.ready     = adv;
   assign rsp_chan.valid     = skid_valid_ff | out_valid_ff;
   assign rsp_chan.rotated_x = skid_valid_ff ? skid_x_ff : out_x_ff;
   assign rsp_chan.rotated_y = skid_valid_ff ? skid_y_ff : out_y_ff;
   assign rsp_chan.rotated_z = skid_valid_ff ? skid_z_ff : out_z_ff;

endmodule

[rtl/pavr_checker.sv]
// ----------------------------------------------------------------------------
// pavr_checker
// Port-level checks of the rotator, bound to the top level.
// ----------------------------------------------------------------------------
module pavr_checker #(
   parameter int COORD_WIDTH = pavr_pkg::COORD_WIDTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [COORD_WIDTH-1:0] rsp_rotated_x,
   input logic signed [COORD_WIDTH-1:0] rsp_rotated_y,
   input logic signed [COORD_WIDTH-1:0] rsp_rotated_z
);

   localparam int CNT_W = 8;

   logic [CNT_W-1:0] pending_ff;
   logic [CNT_W-1:0] pending_in;

   // transactions accepted and not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + CNT_W'(1);
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("response with no request outstanding");

   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("request side stalled without response backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rotated_x)
         && $stable(rsp_rotated_y) && $stable(rsp_rotated_z)))
      else $error("stalled response changed");

endmodule

bind principal_axis_vector_rotator pavr_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_pavr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_rotated_x (rsp_chan.rotated_x),
   .rsp_rotated_y (rsp_chan.rotated_y),
   .rsp_rotated_z (rsp_chan.rotated_z)
);

[test/tb_principal_axis_vector_rotator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_principal_axis_vector_rotator
// Drives points, angles and axis codes into the rotator and checks every
// rotated point against an in-bench fixed-point model.
// ----------------------------------------------------------------------------
// Directed cases come first: quarter turns, wrapped angles, saturating
// rotations, pass-through and the smallest nonzero angles. Random traffic
// follows, with bursts of source gaps and sink stalls, one full drain in the
// middle and a final stretch at full rate with no idling at all.
// ----------------------------------------------------------------------------
module tb_principal_axis_vector_rotator;
   import pavr_pkg::*;

   localparam int COORD_W        = COORD_WIDTH_DEFAULT;
   localparam int CORDIC_STEPS   = TRIG_ITERATIONS_DEFAULT;
   localparam int DUT_LATENCY    = CORDIC_STEPS + 10;
   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction on either side
   localparam int REPORT_LIMIT   = 200;    // keeps the log short on a broken build

   // pi in Q2.30, and atan(2^-i) in Q2.30, truncated
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint ARCTAN_Q30 [0:23] = '{
      64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6, 64'sh03FEAB76,
      64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55, 64'sh003FFFEA, 64'sh001FFFFD,
      64'sh000FFFFF, 64'sh0007FFFF, 64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF,
      64'sh00007FFF, 64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
      64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F
   };

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] Q16_ONE   = 1 <<< 16;

   typedef struct {
      axis_type                        axis;
      logic signed [ANGLE_WIDTH-1:0]   angle;
      logic signed [COORD_W-1:0]       px;
      logic signed [COORD_W-1:0]       py;
      logic signed [COORD_W-1:0]       pz;
   } point_item;

   typedef struct {
      logic signed [COORD_W-1:0] rx;
      logic signed [COORD_W-1:0] ry;
      logic signed [COORD_W-1:0] rz;
   } rotated_point;

   typedef struct {
      longint cos_q30;
      longint sin_q30;
   } trig_pair;

   logic clock;
   logic reset;

   pavr_req_if #(.COORD_WIDTH(COORD_W)) req_chan ();
   pavr_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_chan ();

   principal_axis_vector_rotator #(
      .COORD_WIDTH     (COORD_W),
      .TRIG_ITERATIONS (CORDIC_STEPS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rotated_point expected_points[$];   // predicted points, oldest first
   int           mismatch_count = 0;
   bit           src_gap_on     = 1'b1;  // random gaps between request transactions
   bit           sink_stall_on  = 1'b1;  // random stalls on the response side

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Fixed-point model
   // -------------------------------------------------------------------------

   // Sine and cosine in Q2.30: wrap to one turn, split off the quadrant,
   // run the CORDIC on the remainder, then fold by quadrant.
   function automatic trig_pair angle_to_trig(input logic signed [ANGLE_WIDTH-1:0] ang);
      longint   a, r, f, x, y, z, dx, dy, c0, s0;
      int       quad;
      int       i;
      trig_pair tp;
      a = ang;
      r = a % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      quad = int'(r / QUARTER_TURN);
      f    = r % QUARTER_TURN;
      if (f == 0) begin
         // exact on the quarter-turn grid
         c0 = ONE_Q30;
         s0 = 0;
      end else begin
         x = CORDIC_GAIN;
         y = 0;
         z = (f * PI_Q30 + QUARTER_TURN) / HALF_TURN;
         for (i = 0; i < CORDIC_STEPS && i < ATAN_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= ARCTAN_Q30[i];
            end else begin
               x += dx;
               y -= dy;
               z += ARCTAN_Q30[i];
            end
         end
         c0 = (x > ONE_Q30) ? ONE_Q30 : (x < -ONE_Q30) ? -longint'(ONE_Q30) : x;
         s0 = (y > ONE_Q30) ? ONE_Q30 : (y < -ONE_Q30) ? -longint'(ONE_Q30) : y;
      end
      case (quad)
         0: begin
            tp.cos_q30 = c0;
            tp.sin_q30 = s0;
         end
         1: begin
            tp.cos_q30 = -s0;
            tp.sin_q30 = c0;
         end
         2: begin
            tp.cos_q30 = -c0;
            tp.sin_q30 = -s0;
         end
         default: begin
            tp.cos_q30 = s0;
            tp.sin_q30 = -c0;
         end
      endcase
      return tp;
   endfunction

   // coordinate * trig / 2^30, nearest, halves away from zero
   function automatic longint scale_q30(input longint coord, input longint trig);
      longint mag_c, mag_t, mag;
      mag_c = (coord < 0) ? -coord : coord;
      mag_t = (trig < 0) ? -trig : trig;
      mag   = (mag_c * mag_t + (longint'(1) << 29)) >>> 30;
      return ((coord < 0) != (trig < 0)) ? -mag : mag;
   endfunction

   function automatic logic signed [COORD_W-1:0] clip_coord(input longint v);
      longint hi, lo;
      hi = (longint'(1) << (COORD_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[COORD_W-1:0];
   endfunction

   function automatic rotated_point predict_rotation(input point_item it);
      longint       x, y, z;
      trig_pair     tp;
      rotated_point rp;
      x  = it.px;
      y  = it.py;
      z  = it.pz;
      tp = angle_to_trig(it.angle);
      // axis coordinate and pass-through come back untouched
      rp.rx = it.px;
      rp.ry = it.py;
      rp.rz = it.pz;
      case (it.axis)
         AXIS_X: begin
            rp.ry = clip_coord(scale_q30(y, tp.cos_q30) - scale_q30(z, tp.sin_q30));
            rp.rz = clip_coord(scale_q30(y, tp.sin_q30) + scale_q30(z, tp.cos_q30));
         end
         AXIS_Y: begin
            rp.rx = clip_coord(scale_q30(x, tp.cos_q30) + scale_q30(z, tp.sin_q30));
            rp.rz = clip_coord(scale_q30(z, tp.cos_q30) - scale_q30(x, tp.sin_q30));
         end
         AXIS_Z: begin
            rp.rx = clip_coord(scale_q30(x, tp.cos_q30) - scale_q30(y, tp.sin_q30));
            rp.ry = clip_coord(scale_q30(x, tp.sin_q30) + scale_q30(y, tp.cos_q30));
         end
         default: ;
      endcase
      return rp;
   endfunction

   // -------------------------------------------------------------------------
   // Scoreboard: predict on each request transaction, compare on each
   // response transaction. Pop before push so one edge never pairs a
   // response with the request taken at that same edge.
   // -------------------------------------------------------------------------
   task automatic compare_coord(input string label,
                                input logic signed [COORD_W-1:0] want,
                                input logic signed [COORD_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rotated_point want;
      point_item    seen;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected response, expected none, actual %h %h %h",
                           $time, rsp_chan.rotated_x, rsp_chan.rotated_y, rsp_chan.rotated_z);
            end else begin
               want = expected_points.pop_front();
               compare_coord("rotated_x", want.rx, rsp_chan.rotated_x);
               compare_coord("rotated_y", want.ry, rsp_chan.rotated_y);
               compare_coord("rotated_z", want.rz, rsp_chan.rotated_z);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            seen.axis  = axis_type'(req_chan.axis_select);
            seen.angle = req_chan.angle;
            seen.px    = req_chan.point_x;
            seen.py    = req_chan.point_y;
            seen.pz    = req_chan.point_z;
            expected_points.push_back(predict_rotation(seen));
         end
      end
   end

   // watchdog: too long without any transaction means a hang
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d points outstanding",
                     $time, expected_points.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // response side: ready high except during random stall bursts
   initial begin : sink_ready
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (sink_stall_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Called and returns at a rising edge; leaves valid high after the
   // transaction so back-to-back points go out at full rate.
   task automatic send_point(input point_item it);
      if (src_gap_on && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.axis_select <= it.axis;
      req_chan.angle       <= it.angle;
      req_chan.point_x     <= it.px;
      req_chan.point_y     <= it.py;
      req_chan.point_z     <= it.pz;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   function automatic point_item make_point(input axis_type axis, input int ang,
                                            input logic signed [COORD_W-1:0] x,
                                            input logic signed [COORD_W-1:0] y,
                                            input logic signed [COORD_W-1:0] z);
      point_item it;
      it.axis  = axis;
      it.angle = ang[ANGLE_WIDTH-1:0];
      it.px    = x;
      it.py    = y;
      it.pz    = z;
      return it;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2, 3, 4: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
         default: return $urandom();
      endcase
   endfunction

   function automatic int rand_angle();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom();   // whole field, wraps past a turn
         5, 6:          return int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
         7:             return int'($urandom_range(0, 8)) * QUARTER_TURN - FULL_TURN
                               + int'($urandom_range(0, 2)) - 1;
         default:       return int'($urandom_range(0, 512)) - 256;
      endcase
   endfunction

   function automatic point_item rand_point();
      return make_point(axis_type'($urandom_range(0, 3)), rand_angle(),
                        rand_coord(), rand_coord(), rand_coord());
   endfunction

   task automatic send_random_points(input int count);
      int n;
      for (n = 0; n < count; n++) send_point(rand_point());
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // quarter turns about each axis, and every quadrant about Z
   task automatic test_cardinal_angles();
      logic signed [COORD_W-1:0] x, y, z;
      x = Q16_ONE;
      y = 2 * Q16_ONE;
      z = 3 * Q16_ONE;
      send_point(make_point(AXIS_X, QUARTER_TURN, x, y, z));
      send_point(make_point(AXIS_Y, QUARTER_TURN, x, y, z));
      send_point(make_point(AXIS_Z, QUARTER_TURN, x, y, z));
      send_point(make_point(AXIS_Z, 0, x, y, z));
      send_point(make_point(AXIS_Z, HALF_TURN, x, y, z));
      send_point(make_point(AXIS_Z, THREE_QUARTER_TURN, x, y, z));
      send_point(make_point(AXIS_Z, -QUARTER_TURN, x, y, z));
   endtask

   // whole turns and field extremes beyond one turn must wrap
   task automatic test_angle_wrap();
      logic signed [COORD_W-1:0] x, y, z;
      x = 5 * Q16_ONE;
      y = -7 * Q16_ONE;
      z = Q16_ONE / 3;
      send_point(make_point(AXIS_Y, FULL_TURN, x, y, z));
      send_point(make_point(AXIS_X, -FULL_TURN, x, y, z));
      send_point(make_point(AXIS_Z, (1 << (ANGLE_WIDTH - 1)) - 1, x, y, z));
      send_point(make_point(AXIS_Y, -(1 << (ANGLE_WIDTH - 1)), x, y, z));
      send_point(make_point(AXIS_Z, FULL_TURN + QUARTER_TURN, x, y, z));
   endtask

   // rotations of extreme points whose results overflow and clip
   task automatic test_saturation();
      send_point(make_point(AXIS_Z, QUARTER_TURN / 2, COORD_MAX, COORD_MAX, 0));
      send_point(make_point(AXIS_Z, QUARTER_TURN / 2, COORD_MIN, COORD_MIN, COORD_MAX));
      send_point(make_point(AXIS_X, 3 * QUARTER_TURN / 2, COORD_MIN, COORD_MAX, COORD_MIN));
      send_point(make_point(AXIS_Y, -QUARTER_TURN / 2, COORD_MIN, -1, COORD_MAX));
   endtask

   // pass-through code returns the point as is, whatever the angle
   task automatic test_pass_through();
      send_point(make_point(AXIS_NONE, 12345, COORD_MAX, COORD_MIN, -1));
      send_point(make_point(AXIS_NONE, -(1 << (ANGLE_WIDTH - 1)), 0, COORD_MIN + 1, 1));
   endtask

   // one LSB of angle either way
   task automatic test_fine_angles();
      send_point(make_point(AXIS_Z, 1, 32'sh1234_5678, -32'sh0765_4321, 32'sh0000_8000));
      send_point(make_point(AXIS_X, -1, -32'sh0000_8000, 32'sh7000_0000, -32'sh6FFF_FFFF));
   endtask

   task automatic test_random_mixed(input int count);
      src_gap_on    = 1'b1;
      sink_stall_on = 1'b1;
      send_random_points(count);
   endtask

   // source at full rate, sink stalling: exercises the skid register
   task automatic test_sink_backpressure(input int count);
      src_gap_on    = 1'b0;
      sink_stall_on = 1'b1;
      send_random_points(count);
   endtask

   // hold the source until the pipeline is empty, then restart
   task automatic test_drain_pause(input int count);
      src_gap_on    = 1'b1;
      sink_stall_on = 1'b1;
      send_random_points(count);
      wait_for_results();
      send_random_points(count);
   endtask

   task automatic test_full_rate(input int count);
      src_gap_on    = 1'b0;
      sink_stall_on = 1'b0;
      send_random_points(count);
   endtask

   initial begin : test_sequence
      req_chan.valid       <= 1'b0;
      req_chan.axis_select <= AXIS_NONE;
      req_chan.angle       <= '0;
      req_chan.point_x     <= '0;
      req_chan.point_y     <= '0;
      req_chan.point_z     <= '0;
      reset                <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_cardinal_angles();
      test_angle_wrap();
      test_saturation();
      test_pass_through();
      test_fine_angles();

      test_random_mixed(600);
      test_sink_backpressure(300);
      test_drain_pause(30);
      test_full_rate(690);

      wait_for_results();
      repeat (DUT_LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
